// File: sv/dst_pkg.sv
// dst_pkg: shared constants, codes and controller/datapath handshake types
// for the dirty span tracker
// no dependencies

package dst_pkg;

  // default sizes, handed down as parameters from the top level
  localparam int DST_MAX_COLS = 256;
  localparam int DST_MAX_ROWS = 128;

  // configuration port
  localparam int CFG_W = 9;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [8:0] WIDTH_RST  = 9'd100;
  localparam logic [7:0] HEIGHT_RST = 8'd30;

  typedef enum logic [1:0] {
    CMD_MARK     = 2'd0,
    CMD_READ     = 2'd1,
    CMD_READ_CLR = 2'd2,
    CMD_CLR_FLAG = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_DRAIN,
    ST_REPORT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic ld_item;
    logic row_step;
    logic rd_en;
    logic mark_rd;
    logic clr_wr;
    logic zero_wr;
    logic out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_mark;
    logic mark_rows;
    logic is_read;
    logic read_ok;
    logic is_read_clr;
    logic row_last;
    logic clr_last;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

// File: sv/dst_in_if.sv
// dst_in_if: command word channel into the dirty span tracker
// valid/ready handshake, no package dependency

interface dst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] x_start;
  logic signed [15:0] y_start;
  logic signed [15:0] x_end;
  logic signed [15:0] y_end;

  modport source (output valid, cmd, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, output ready);
endinterface

// File: sv/dst_out_if.sv
// dst_out_if: result word channel out of the dirty span tracker
// valid/ready handshake, no package dependency

interface dst_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       first_valid;
  logic [7:0] first_begin;
  logic [7:0] first_finish;
  logic       second_valid;
  logic [7:0] second_begin;
  logic [7:0] second_finish;
  logic       changed;

  modport source (output valid, accepted, first_valid, first_begin, first_finish,
                  second_valid, second_begin, second_finish, changed,
                  input ready);
  modport sink   (input valid, accepted, first_valid, first_begin, first_finish,
                  second_valid, second_begin, second_finish, changed,
                  output ready);
endinterface

// File: sv/dirty_span_tracker.sv
// dirty span tracker: for each screen row, up to two dirty column spans.
// A mark word carries a signed rectangle, clipped to the configured screen
// size; each covered row has its span filled, skipped or merged. Read and
// read-and-clear words report one row; a clear-flag word drops the changed
// flag. One result word for every command word. After reset the block
// sweeps the row memory empty and takes no command word meanwhile
// (configuration writes are taken during the sweep too). A mark that
// covers rows walks the row memory, one read and one write port, one row
// a cycle through a three-stage read, cost and write-back pipeline that
// then drains before its result. A read of a row on screen reads the row
// memory first; every other word, a dropped mark or an off-screen read
// included, goes straight to its result. Words are worked one at a time,
// but a new word is taken while the previous result still sits in the
// output register; the next result waits until that register empties.
// Configuration must be written only while idle; the block does not check.
// depends on dst_pkg, dst_in_if, dst_out_if, dst_ctrl, dst_datapath

module dirty_span_tracker #(
  parameter int MAX_COLS = dst_pkg::DST_MAX_COLS,
  parameter int MAX_ROWS = dst_pkg::DST_MAX_ROWS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [dst_pkg::IDX_W-1:0]  cfg_index,
  input  logic [dst_pkg::CFG_W-1:0]  cfg_data,
  dst_in_if.sink                     item,
  dst_out_if.source                  result
);
  import dst_pkg::*;

  // command and status between the sequencer and the datapath
  ctl_t ctl;
  sts_t sts;
  logic in_ready;

  // sequencer: clearing pass, row walk, result hand-off
  dst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // word is taken only while the sequencer is idle
  assign item.ready = in_ready;

  // clipping, row memory, merge pipeline and result register
  dst_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (item.cmd),
    .x_start       (item.x_start),
    .y_start       (item.y_start),
    .x_end         (item.x_end),
    .y_end         (item.y_end),
    .ctl           (ctl),
    .sts           (sts),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .accepted      (result.accepted),
    .first_valid   (result.first_valid),
    .first_begin   (result.first_begin),
    .first_finish  (result.first_finish),
    .second_valid  (result.second_valid),
    .second_begin  (result.second_begin),
    .second_finish (result.second_finish),
    .changed       (result.changed)
  );

endmodule

// File: sv/dst_ctrl.sv
// dst_ctrl: sequencing state machine of the dirty span tracker
// depends on dst_pkg (state_t, ctl_t, sts_t)

module dst_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dst_pkg::sts_t   sts,
  output dst_pkg::ctl_t   ctl
);
  import dst_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        // sweep all rows to empty after reset
        ctl.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end else begin
          ctl.row_step = 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.ld_item = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_mark && sts.mark_rows) begin
          // one row read per cycle into the merge pipeline
          ctl.rd_en   = 1'b1;
          ctl.mark_rd = 1'b1;
          if (sts.row_last) begin
            state_next = ST_DRAIN;
          end else begin
            ctl.row_step = 1'b1;
          end
        end else if (sts.is_read && sts.read_ok) begin
          ctl.rd_en  = 1'b1;
          state_next = ST_RDATA;
        end else begin
          state_next = ST_REPORT;
        end
      end
      ST_RDATA: begin
        ctl.zero_wr = sts.is_read_clr;
        state_next  = ST_REPORT;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: sv/dst_datapath.sv
// dst_datapath: clipping, row span memory, three-stage merge pipeline and
// result register of the dirty span tracker
// depends on dst_pkg (codes, ctl_t, sts_t)

module dst_datapath #(
  parameter int MAX_COLS = dst_pkg::DST_MAX_COLS,
  parameter int MAX_ROWS = dst_pkg::DST_MAX_ROWS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [dst_pkg::IDX_W-1:0]    cfg_index,
  input  logic [dst_pkg::CFG_W-1:0]    cfg_data,
  input  logic [1:0]                   cmd,
  input  logic signed [15:0]           x_start,
  input  logic signed [15:0]           y_start,
  input  logic signed [15:0]           x_end,
  input  logic signed [15:0]           y_end,
  input  dst_pkg::ctl_t                ctl,
  output dst_pkg::sts_t                sts,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         accepted,
  output logic                         first_valid,
  output logic [7:0]                   first_begin,
  output logic [7:0]                   first_finish,
  output logic                         second_valid,
  output logic [7:0]                   second_begin,
  output logic [7:0]                   second_finish,
  output logic                         changed
);
  import dst_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int CB = CW + 1;                  // signed column, holds -1
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int KW = CW + 3;                  // signed cost
  localparam int SW = 1 + 2 * CB;              // one slot
  localparam int EW = 2 * SW;                  // one row entry
  localparam int OB = (CB > 8) ? CB : 8;
  localparam int XW = 18;

  function automatic logic [7:0] col8(input logic signed [CB-1:0] c);
    logic signed [OB-1:0] t;
    t = OB'(c);
    return t[7:0];
  endfunction

  // configuration
  logic [8:0] width_reg;
  logic [7:0] height_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RST;
      height_reg <= HEIGHT_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_SCREEN_WIDTH) begin
        width_reg <= cfg_data;
      end else if (cfg_index == REG_SCREEN_HEIGHT) begin
        height_reg <= cfg_data[7:0];
      end
    end
  end

  // clipping of the incoming word
  logic signed [XW-1:0] w_eff, h_eff, xs_x, xe_x, ys_x, ye_x;
  logic signed [XW-1:0] xs_cl, xe_cl, ys_cl, ye_cl;
  logic                 mark_ok_c, read_ok_c;

  always_comb begin
    w_eff = (width_reg > MAX_COLS) ? XW'(MAX_COLS) : XW'(width_reg);
    h_eff = (height_reg > MAX_ROWS) ? XW'(MAX_ROWS) : XW'(height_reg);
    xs_x  = XW'(x_start);
    xe_x  = XW'(x_end);
    ys_x  = XW'(y_start);
    ye_x  = XW'(y_end);
    mark_ok_c = !(xs_x > xe_x || xs_x >= w_eff || xe_x[XW-1] ||
                  ys_x > ye_x || ys_x >= h_eff || ye_x[XW-1]);
    read_ok_c = !ys_x[XW-1] && (ys_x < h_eff);
    xs_cl = xs_x[XW-1] ? '0 : xs_x;
    ys_cl = ys_x[XW-1] ? '0 : ys_x;
    xe_cl = (xe_x > w_eff - XW'(1)) ? w_eff - XW'(1) : xe_x;
    ye_cl = (ye_x > h_eff - XW'(1)) ? h_eff - XW'(1) : ye_x;
  end

  cmd_code_t            cmd_q;
  logic                 mark_ok_q, read_ok_q, rows_q;
  logic signed [CB-1:0] xs_q, xe_q;
  logic [RW-1:0]        y_hi;
  logic [RW-1:0]        row;

  always_ff @(posedge clk) begin
    if (ctl.ld_item) begin
      cmd_q     <= cmd_code_t'(cmd);
      mark_ok_q <= mark_ok_c;
      read_ok_q <= read_ok_c;
      rows_q    <= (h_eff != '0);
      xs_q      <= xs_cl[CB-1:0];
      xe_q      <= xe_cl[CB-1:0];
      y_hi      <= ye_cl[RW-1:0];
    end
  end

  // row counter, also walks the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (ctl.ld_item) begin
      row <= ys_cl[RW-1:0];
    end else if (ctl.row_step) begin
      row <= row + RW'(1);
    end
  end

  // row span memory
  logic [EW-1:0] mem [MAX_ROWS];
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [RW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[row];
    end
  end

  logic                 v0, v1;
  logic signed [CB-1:0] s0, e0, s1, e1;

  assign v0 = rd_data[SW-1];
  assign s0 = $signed(rd_data[SW-2 -: CB]);
  assign e0 = $signed(rd_data[CB-1:0]);
  assign v1 = rd_data[EW-1];
  assign s1 = $signed(rd_data[EW-2 -: CB]);
  assign e1 = $signed(rd_data[SW+CB-1:SW]);

  // stage b: compares, extremes and merge costs
  logic                 pb_vld;
  logic [RW-1:0]        pb_addr;
  logic                 cov_b, adj_b;
  logic signed [CB-1:0] mn0_b, mx0_b, mx1_b, mn1_b;
  logic signed [KW-1:0] cost0_b, cost1_b, cost2_b, cost3_b;

  always_comb begin
    cov_b = (xs_q >= s0 && xe_q <= e0) || (v1 && xs_q >= s1 && xe_q <= e1);
    adj_b = (KW'(xs_q) <= KW'(e0) + KW'(1)) && (KW'(xe_q) + KW'(1) >= KW'(s0));
    mn0_b = (xs_q < s0) ? xs_q : s0;
    mx0_b = (xe_q > e0) ? xe_q : e0;
    mx1_b = (xe_q > e1) ? xe_q : e1;
    mn1_b = (xs_q < s1) ? xs_q : s1;
    cost0_b = KW'(xe_q) - KW'(xs_q) + KW'(e1) - KW'(s0);
    cost1_b = KW'(mx0_b) - KW'(mn0_b) + KW'(e1) - KW'(e0);
    cost2_b = KW'(mx1_b) - KW'(mn0_b) - KW'(1);
    cost3_b = KW'(e0) - KW'(s0) + KW'(mx1_b) - KW'(mn1_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pb_vld <= 1'b0;
    end else begin
      pb_vld <= ctl.rd_en && ctl.mark_rd;
    end
    if (ctl.rd_en) begin
      pb_addr <= row;
    end
  end

  // stage c: pick the merge and write back
  logic                 pc_vld;
  logic [RW-1:0]        pc_addr;
  logic                 pc_v0, pc_v1, pc_cov, pc_adj, pc_lt0, pc_gt0;
  logic signed [CB-1:0] pc_s0, pc_e0, pc_s1, pc_e1;
  logic signed [CB-1:0] pc_mn0, pc_mx0, pc_mx1, pc_mn1;
  logic signed [KW-1:0] pc_cost0, pc_cost1, pc_cost2, pc_cost3;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_vld <= 1'b0;
    end else begin
      pc_vld <= pb_vld;
    end
    pc_addr  <= pb_addr;
    pc_v0    <= v0;
    pc_v1    <= v1;
    pc_s0    <= s0;
    pc_e0    <= e0;
    pc_s1    <= s1;
    pc_e1    <= e1;
    pc_cov   <= cov_b;
    pc_adj   <= adj_b;
    pc_lt0   <= xs_q < s0;
    pc_gt0   <= xs_q > s0;
    pc_mn0   <= mn0_b;
    pc_mx0   <= mx0_b;
    pc_mx1   <= mx1_b;
    pc_mn1   <= mn1_b;
    pc_cost0 <= cost0_b;
    pc_cost1 <= cost1_b;
    pc_cost2 <= cost2_b;
    pc_cost3 <= cost3_b;
  end

  logic                 c1, c2, c3;
  logic signed [KW-1:0] b01, b012;
  logic                 nv0, nv1;
  logic signed [CB-1:0] ns0, ne0, ns1, ne1;

  always_comb begin
    // full merge wins ties
    c1   = pc_cost1 < pc_cost0;
    b01  = c1 ? pc_cost1 : pc_cost0;
    c2   = pc_cost2 <= b01;
    b012 = c2 ? pc_cost2 : b01;
    c3   = pc_cost3 < b012;
  end

  always_comb begin
    nv0 = pc_v0;
    ns0 = pc_s0;
    ne0 = pc_e0;
    nv1 = pc_v1;
    ns1 = pc_s1;
    ne1 = pc_e1;
    priority if (!pc_v0) begin
      nv0 = 1'b1;
      ns0 = xs_q;
      ne0 = xe_q;
    end else if (!pc_v1) begin
      priority if (pc_adj) begin
        ns0 = pc_mn0;
        ne0 = pc_mx0;
      end else if (pc_lt0) begin
        ns0 = xs_q;
        ne0 = xe_q;
        nv1 = 1'b1;
        ns1 = pc_s0;
        ne1 = pc_e0;
      end else begin
        nv1 = 1'b1;
        ns1 = xs_q;
        ne1 = xe_q;
      end
    end else if (c3) begin
      // widen second slot
      ns1 = pc_mn1;
      ne1 = pc_mx1;
    end else if (c2) begin
      // everything into one span
      ns0 = pc_mn0;
      ne0 = pc_mx1;
      nv1 = 1'b0;
      ns1 = '0;
      ne1 = '0;
    end else if (c1) begin
      ns0 = pc_mn0;
      ne0 = pc_mx0;
    end else if (pc_gt0) begin
      // old spans joined, new span kept apart
      ns0 = pc_s0;
      ne0 = pc_e1;
      ns1 = xs_q;
      ne1 = xe_q;
    end else begin
      ns0 = xs_q;
      ne0 = xe_q;
      ns1 = pc_s0;
      ne1 = pc_e1;
    end
  end

  // single write port: merge write-back, clearing pass or read-and-clear
  always_comb begin
    if (pc_vld) begin
      wr_en   = !(pc_v0 && pc_cov);
      wr_addr = pc_addr;
      wr_data = {nv1, ns1, ne1, nv0, ns0, ne0};
    end else begin
      wr_en   = ctl.clr_wr || ctl.zero_wr;
      wr_addr = row;
      wr_data = '0;
    end
  end

  // result register and changed flag
  logic changed_flag, changed_next, rd_ok, acc_next;

  always_comb begin
    changed_next = changed_flag;
    if (cmd_q == CMD_MARK && mark_ok_q) begin
      changed_next = 1'b1;
    end else if (cmd_q == CMD_CLR_FLAG) begin
      changed_next = 1'b0;
    end
    rd_ok    = (cmd_q == CMD_READ || cmd_q == CMD_READ_CLR) && read_ok_q;
    acc_next = (cmd_q == CMD_MARK) ? mark_ok_q : rd_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      changed_flag <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid    <= 1'b1;
      changed_flag <= changed_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      accepted      <= acc_next;
      first_valid   <= rd_ok && v0;
      first_begin   <= (rd_ok && v0) ? col8(s0) : 8'd0;
      first_finish  <= (rd_ok && v0) ? col8(e0) : 8'd0;
      second_valid  <= rd_ok && v1;
      second_begin  <= (rd_ok && v1) ? col8(s1) : 8'd0;
      second_finish <= (rd_ok && v1) ? col8(e1) : 8'd0;
      changed       <= changed_next;
    end
  end

  // status to the controller
  always_comb begin
    sts.is_mark     = (cmd_q == CMD_MARK);
    sts.mark_rows   = mark_ok_q && rows_q;
    sts.is_read     = (cmd_q == CMD_READ || cmd_q == CMD_READ_CLR);
    sts.read_ok     = read_ok_q;
    sts.is_read_clr = (cmd_q == CMD_READ_CLR);
    sts.row_last    = (row == y_hi);
    sts.clr_last    = (row == RW'(MAX_ROWS - 1));
    sts.pipe_busy   = pb_vld || pc_vld;
    sts.out_free    = !out_valid || out_ready;
  end

  a_wr_port_free: assert property (@(posedge clk) disable iff (rst)
    pc_vld |-> !(ctl.clr_wr || ctl.zero_wr))
    else $error("merge write-back collides with a clearing write");

  a_pipe_advance: assert property (@(posedge clk) disable iff (rst)
    pb_vld |=> pc_vld)
    else $error("merge pipeline lost a row");

  a_idle_on_load: assert property (@(posedge clk) disable iff (rst)
    ctl.ld_item |-> !(pb_vld || pc_vld))
    else $error("new word taken while rows still in flight");

  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    (pc_vld && wr_en && nv1) |-> nv0)
    else $error("second slot written valid with first slot empty");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule
